// ===== hw/rtl/scfcd_pkg.sv =====
package scfcd_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [2:0]  PosFirst = 3'd0;
  localparam logic [2:0]  PosHum   = 3'd2;
  localparam logic [2:0]  PosTemp  = 3'd5;
  localparam logic [2:0]  PosCrcLo = 3'd6;
  localparam logic [2:0]  PosLast  = 3'd7;
  localparam logic [2:0]  CrcBytes = 3'd6;
  localparam int unsigned SignBit  = 15;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic               crc_ok;
    logic signed [15:0] temperature_tenths;
    logic        [15:0] humidity_tenths;
  } out_req_t;

  // CRC-16/MODBUS, reflected, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== hw/rtl/scfcd_frame.sv =====
module scfcd_frame import scfcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_req_t  req_i,
  output logic     last_o,
  output out_req_t result_o
);

  logic [2:0]  pos_q, pos_d, pos;
  logic [15:0] crc_q, crc_d, crc_base;
  logic [31:0] meas_q, meas_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] hum_q, hum_d;
  logic [15:0] mag, temp_new;
  logic        crc_ok;

  assign pos      = req_i.frame_start ? PosFirst : pos_q;
  assign last_o   = (pos == PosLast);
  assign crc_base = (pos == PosFirst) ? CrcInit : crc_q;

  // sign and magnitude to two's complement; negative zero falls out as 0
  assign mag      = {1'b0, meas_q[14:0]};
  assign temp_new = meas_q[SignBit] ? (16'h0000 - mag) : mag;
  assign crc_ok   = ({req_i.rx_byte, crc_lo_q} == crc_q);

  always_comb begin
    pos_d    = pos + 3'd1;
    crc_d    = crc_q;
    meas_d   = meas_q;
    crc_lo_d = crc_lo_q;
    temp_d   = temp_q;
    hum_d    = hum_q;
    if (pos < CrcBytes) begin
      crc_d = crc16_byte(crc_base, req_i.rx_byte);
    end
    if (pos >= PosHum && pos <= PosTemp) begin
      // byte 2 lands in the top bits
      meas_d = {meas_q[23:0], req_i.rx_byte};
    end
    if (pos == PosCrcLo) begin
      crc_lo_d = req_i.rx_byte;
    end
    if (last_o && crc_ok) begin
      temp_d = temp_new;
      hum_d  = meas_q[31:16];
    end
  end

  always_comb begin
    result_o.crc_ok             = crc_ok;
    result_o.temperature_tenths = $signed(temp_d);
    result_o.humidity_tenths    = hum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosFirst;
      crc_q    <= CrcInit;
      meas_q   <= '0;
      crc_lo_q <= '0;
      temp_q   <= '0;
      hum_q    <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      meas_q   <= meas_d;
      crc_lo_q <= crc_lo_d;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
    end
  end

endmodule

// ===== hw/rtl/sensor_frame_crc_check_decode_top.sv =====
// Checked sensor frame decoder. Takes an eight-byte temperature/humidity
// sensor response one byte per request and returns one result per frame, on
// its last byte: crc_ok (CRC-16/MODBUS over bytes 0-5 against bytes 6-7, low
// byte first), and the last good temperature and humidity in integer tenths.
// On a CRC mismatch the held values are returned unchanged. frame_start
// forces a byte to be taken as byte 0 and drops any partial frame. A new
// byte is accepted every cycle while no last byte waits on a stalled result;
// a result passes through the input register and the result register, with
// the byte-wide CRC update done combinationally between them. While a result
// waits under stall, a last byte stays in the input register.
module sensor_frame_crc_check_decode_top import scfcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     in_vld_q, in_vld_d;
  in_req_t  in_q;
  logic     out_vld_q, out_vld_d;
  out_req_t out_q;
  out_req_t result;
  logic     last;
  logic     out_free;
  logic     in_move;
  logic     in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_move    = in_vld_q && (!last || out_free);
  assign in_stall_o = in_vld_q && !in_move;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take || (in_vld_q && !in_move);

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (in_move && last) begin
      out_vld_d = 1'b1;
    end
  end

  scfcd_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_move),
    .req_i    (in_q),
    .last_o   (last),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
    if (in_move && last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  a_rise_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_move && last))
    else $error("result appeared without a last byte");

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with empty input register");

  a_held_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !in_move) |=> (in_vld_q && $stable(in_q)))
    else $error("unprocessed byte lost from input register");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_move && last) |-> out_free)
    else $error("result register overwritten while stalled");
`endif

endmodule
